/* src/lid_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lid_pkg
// Shared constants, types and the sine reference table of the demodulator.
// ----------------------------------------------------------------------------
package lid_pkg;

  localparam int BLOCK_LENGTH = 300;
  localparam int REF_PERIOD   = 100;
  localparam int POS_W        = $clog2(BLOCK_LENGTH);
  localparam int REF_W        = $clog2(REF_PERIOD);
  localparam int SAMPLE_W     = 12;
  localparam int SUM_W        = 21;
  localparam int MEAN_W       = 20;
  localparam int DIVD_W       = SUM_W + 8;
  // mean = floor(x * MEAN_RECIP / 2^MEAN_SHIFT), exact for every x below 2^DIVD_W
  localparam int MEAN_SHIFT   = DIVD_W + POS_W;
  localparam int MEAN_RECIP_W = DIVD_W + 1;
  localparam int MEAN_PROD_W  = DIVD_W + MEAN_RECIP_W;
  localparam int SINE_W       = 16;
  localparam int OUT_W        = 37;
  localparam int FILT_W       = 53;
  localparam int COEF_W       = 31;
  localparam int GAIN_W       = 16;
  localparam int CFG_IDX_W    = 2;

  localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP = MEAN_RECIP_W'(
    ((64'd1 << MEAN_SHIFT) + 64'(BLOCK_LENGTH) - 64'd1) / 64'(BLOCK_LENGTH));

  localparam logic [CFG_IDX_W-1:0] REG_POLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN = 2'd2;

  localparam logic [COEF_W-1:0] POLE_RESET     = 31'd2146471910;
  localparam logic [COEF_W-1:0] IN_GAIN_RESET  = 31'd505870;
  localparam logic [GAIN_W-1:0] OUT_GAIN_RESET = 16'd23170;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [MEAN_W-1:0]   mean;
    logic [POS_W-1:0]    pos;
    logic [REF_W-1:0]    ref_idx;
    logic                last;
  } lid_item_t;

  typedef logic signed [SINE_W-1:0] sine_lut_t [REF_PERIOD];

  // sin(pi/2 * r/P) in Q1.15 by a Taylor series in Q30
  function automatic logic [63:0] quarter_sine(input logic [63:0] r);
    logic [63:0] f, x, x2, t, s;
    f  = (r << 30) / REF_PERIOD;
    x  = (f * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t  = 64'd1073741824 - x2 / 72;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
    s  = (((x * t) >> 30) + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s;
  endfunction

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t   lut;
    logic [63:0] q, quad, r, v;
    for (int k = 0; k < REF_PERIOD; k++) begin
      q    = 64'(4 * k);
      quad = q / REF_PERIOD;
      r    = q % REF_PERIOD;
      v    = quad[0] ? quarter_sine(64'(REF_PERIOD) - r) : quarter_sine(r);
      lut[k] = quad[1] ? -$signed(v[SINE_W-1:0]) : $signed(v[SINE_W-1:0]);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

/* src/lid_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lid_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/lid_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lid_fifo
// Four-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module lid_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lid_pkg::lid_item_t push_data,
  output logic              full,
  input  logic              pop,
  output lid_pkg::lid_item_t pop_data,
  output logic              empty
);
  import lid_pkg::*;

  lid_item_t  slot_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r;

  assign full     = (count_r == 3'd4);
  assign empty    = (count_r == 3'd0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 2'd1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      count_r <= count_r + 3'(push) - 3'(pop);
    end
  end

endmodule

/* src/lid_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lid_front
// Accepts samples, stores them, tracks position and forms the block mean.
// ----------------------------------------------------------------------------
module lid_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lid_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                          push,
  output lid_pkg::lid_item_t            push_data,
  input  logic                          full
);
  import lid_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_READ = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [SAMPLE_W-1:0]    sample_r;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [REF_W-1:0]       ref_r, ref_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [MEAN_W-1:0]      mean_r, mean_nxt;
  logic                   ready_blk_r, ready_blk_nxt;
  logic [DIVD_W-1:0]      divd_r, divd_nxt;
  logic [MEAN_PROD_W-1:0] mean_prod;
  logic [SAMPLE_W-1:0]    rd_data;
  logic                   accept, last, commit;

  assign in_ready = (state_r == F_IDLE);
  assign accept   = in_valid && in_ready;
  assign last     = (pos_r == POS_W'(BLOCK_LENGTH - 1));
  assign commit   = (state_r == F_READ) && (!ready_blk_r || !full);
  assign push     = commit && ready_blk_r;

  assign push_data = '{sample: rd_data, mean: mean_r, pos: pos_r,
                       ref_idx: ref_r, last: last};

  lid_ram #(.WIDTH(SAMPLE_W), .DEPTH(BLOCK_LENGTH)) u_store (
    .clk     (clk),
    .wr_en   (commit),
    .wr_addr (pos_r),
    .wr_data (sample_r),
    .rd_en   (accept),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  // divide by the block length as a multiply by its scaled reciprocal
  assign mean_prod = MEAN_PROD_W'(divd_r) * MEAN_PROD_W'(MEAN_RECIP);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    ref_nxt       = ref_r;
    sum_nxt       = sum_r;
    mean_nxt      = mean_r;
    ready_blk_nxt = ready_blk_r;
    divd_nxt      = divd_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_READ;
        end
      end
      F_READ: begin
        if (commit) begin
          if (last) begin
            // mean = (sum*256 + N/2) / N
            divd_nxt  = {sum_r + SUM_W'(sample_r), 8'd0} + DIVD_W'(BLOCK_LENGTH / 2);
            sum_nxt   = '0;
            pos_nxt   = '0;
            ref_nxt   = '0;
            state_nxt = F_DIV;
          end else begin
            sum_nxt   = sum_r + SUM_W'(sample_r);
            pos_nxt   = pos_r + POS_W'(1);
            ref_nxt   = (ref_r == REF_W'(REF_PERIOD - 1)) ? '0 : ref_r + REF_W'(1);
            state_nxt = F_IDLE;
          end
        end
      end
      F_DIV: begin
        mean_nxt      = mean_prod[MEAN_SHIFT+MEAN_W-1:MEAN_SHIFT];
        ready_blk_nxt = 1'b1;
        state_nxt     = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
    end
    divd_r <= divd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      pos_r       <= '0;
      ref_r       <= '0;
      sum_r       <= '0;
      mean_r      <= '0;
      ready_blk_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      ref_r       <= ref_nxt;
      sum_r       <= sum_nxt;
      mean_r      <= mean_nxt;
      ready_blk_r <= ready_blk_nxt;
    end
  end

endmodule

/* src/lid_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lid_back
// Mixes each word with the sine reference, runs the IIR low-pass and output
// scale on one shared two-pass multiplier, and holds the result word.
// ----------------------------------------------------------------------------
module lid_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              empty,
  output logic                              pop,
  input  lid_pkg::lid_item_t                pop_data,
  input  logic [lid_pkg::COEF_W-1:0]        pole_coef,
  input  logic [lid_pkg::COEF_W-1:0]        in_gain,
  input  logic [lid_pkg::GAIN_W-1:0]        out_gain,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lid_pkg::OUT_W-1:0]  out_demodulated,
  output logic [lid_pkg::POS_W-1:0]         out_position,
  output logic                              out_block_end
);
  import lid_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_PROD = 3'd1;
  localparam logic [2:0] B_MLO  = 3'd2;
  localparam logic [2:0] B_MHI  = 3'd3;
  localparam logic [2:0] B_MSUM = 3'd4;
  localparam logic [2:0] B_FILT = 3'd5;

  localparam logic [1:0] P_GAIN = 2'd0;
  localparam logic [1:0] P_POLE = 2'd1;
  localparam logic [1:0] P_OUT  = 2'd2;

  logic [2:0]                state_r;
  logic [1:0]                pass_r;
  logic signed [20:0]        cent_r;
  logic signed [SINE_W-1:0]  sine_r;
  logic [POS_W-1:0]          pos_r;
  logic                      last_r;
  logic signed [OUT_W-1:0]   prod_r, prev_r;
  logic [57:0]               p_lo_r;
  logic signed [56:0]        p_hi_r;
  logic signed [53:0]        t1_r;
  logic signed [FILT_W-1:0]  t2_r, filt_r;
  logic signed [FILT_W-1:0]  mop_a;
  logic [COEF_W-1:0]         mop_b;
  logic signed [83:0]        comb;
  logic signed [54:0]        ysum;
  logic signed [53:0]        scaled;
  logic                      out_free;
  logic                      emit;

  assign out_free = !out_valid || out_ready;
  assign pop      = (state_r == B_IDLE) && !empty;
  assign emit     = (state_r == B_MSUM) && (pass_r == P_OUT) && out_free;

  always_comb begin
    case (pass_r)
      P_GAIN:  mop_b = in_gain;
      P_POLE:  mop_b = pole_coef;
      default: mop_b = {15'd0, out_gain};
    endcase
    if (pass_r == P_GAIN) begin
      mop_a = FILT_W'(prev_r) + FILT_W'(prod_r);
    end else begin
      mop_a = filt_r;
    end
  end

  assign comb   = (84'(p_hi_r) <<< 27) + $signed(84'(p_lo_r));
  assign ysum   = 55'(t1_r) + 55'(t2_r);
  assign scaled = comb[83:30];

  always_ff @(posedge clk) begin
    if (pop) begin
      cent_r <= $signed({1'b0, pop_data.sample, 8'd0}) - $signed({1'b0, pop_data.mean});
      sine_r <= SINE_LUT[pop_data.ref_idx];
      pos_r  <= pop_data.pos;
      last_r <= pop_data.last;
    end
    if (state_r == B_PROD) begin
      prod_r <= OUT_W'(cent_r) * OUT_W'(sine_r);
    end
    if (state_r == B_MLO) begin
      p_lo_r <= 58'(mop_a[26:0]) * 58'(mop_b);
    end
    if (state_r == B_MHI) begin
      p_hi_r <= 57'($signed(mop_a[52:27])) * $signed(57'(mop_b));
    end
    if (state_r == B_MSUM && pass_r == P_GAIN) begin
      t1_r <= comb[68:15];
    end
    if (state_r == B_MSUM && pass_r == P_POLE) begin
      t2_r <= comb[83:31];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      pass_r    <= P_GAIN;
      prev_r    <= '0;
      filt_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (pop) begin
            pass_r  <= P_GAIN;
            state_r <= B_PROD;
          end
        end
        B_PROD: state_r <= B_MLO;
        B_MLO:  state_r <= B_MHI;
        B_MHI:  state_r <= B_MSUM;
        B_MSUM: begin
          case (pass_r)
            P_GAIN: begin
              prev_r  <= prod_r;
              pass_r  <= P_POLE;
              state_r <= B_MLO;
            end
            P_POLE: state_r <= B_FILT;
            default: begin
              // hold until the result register is free
              if (out_free) begin
                out_valid     <= 1'b1;
                out_position  <= pos_r;
                out_block_end <= last_r;
                if (scaled[53:36] != {18{scaled[53]}}) begin
                  out_demodulated <= scaled[53] ? {1'b1, 36'd0} : {1'b0, {36{1'b1}}};
                end else begin
                  out_demodulated <= scaled[OUT_W-1:0];
                end
                state_r <= B_IDLE;
              end
            end
          endcase
        end
        B_FILT: begin
          if (ysum[54:52] != {3{ysum[54]}}) begin
            filt_r <= ysum[54] ? {1'b1, 52'd0} : {1'b0, {52{1'b1}}};
          end else begin
            filt_r <= ysum[FILT_W-1:0];
          end
          pass_r  <= P_OUT;
          state_r <= B_MLO;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

/* src/lock_in_demodulator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock_in_demodulator
// Single-phase lock-in: block mean removal, sine mixing, IIR low-pass, scale.
// Accepted samples go through the front and the queue to the back. Front and
// back each take a new item only once done with the last; the back, on its
// shared two-pass multiplier, sets the sustained rate. At each block end the
// front also forms the mean by the reciprocal multiply before taking a sample.
// Reset (synchronous, rst_n low) clears control, filter state and registers.
// ----------------------------------------------------------------------------
module lock_in_demodulator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lid_pkg::SAMPLE_W-1:0]      in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lid_pkg::OUT_W-1:0]  out_demodulated,
  output logic [lid_pkg::POS_W-1:0]         out_position,
  output logic                              out_block_end,
  input  logic                              cfg_write_en,
  input  logic [lid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lid_pkg::COEF_W-1:0]        cfg_data
);
  import lid_pkg::*;

  logic [COEF_W-1:0] pole_r, in_gain_r;
  logic [GAIN_W-1:0] out_gain_r;
  logic              push, full, pop, empty;
  lid_item_t         push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_r     <= POLE_RESET;
      in_gain_r  <= IN_GAIN_RESET;
      out_gain_r <= OUT_GAIN_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_POLE:     pole_r     <= cfg_data;
        REG_IN_GAIN:  in_gain_r  <= cfg_data;
        REG_OUT_GAIN: out_gain_r <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  lid_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  lid_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  lid_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty           (empty),
    .pop             (pop),
    .pop_data        (pop_data),
    .pole_coef       (pole_r),
    .in_gain         (in_gain_r),
    .out_gain        (out_gain_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_demodulated (out_demodulated),
    .out_position    (out_position),
    .out_block_end   (out_block_end)
  );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lock_in_demodulator: samples are streamed in bursts
// through a valid/ready driver, a bit-true model of the block mean removal,
// sine mixing, IIR low-pass and output scaling predicts every result word,
// and a monitor checks each word as the receiver accepts it. Register
// settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import lid_pkg::*;

  localparam int BLK       = 300;
  localparam int PERIOD    = 100;
  localparam int WD_LIMIT  = 20000;
  localparam int LONG_HOLD = 3000;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [36:0] demodulated;
    logic [8:0]         position;
    logic               block_end;
  } lid_word_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [SAMPLE_W-1:0]        in_sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [OUT_W-1:0]    out_demodulated;
  logic [POS_W-1:0]           out_position;
  logic                       out_block_end;
  logic                       cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [COEF_W-1:0]          cfg_data = '0;

  lock_in_demodulator DUT (.*);

  always #10 clk = ~clk;

  // model state
  int                sine_tab [PERIOD];
  logic [11:0]       stored [BLK];
  int unsigned       load_sum;
  int unsigned       mean_q8;
  int unsigned       load_pos;
  bit                have_block;
  longint            last_product;
  longint            iir_state;
  logic [30:0]       pole_reg;
  logic [30:0]       in_gain_reg;
  logic [15:0]       out_gain_reg;

  logic [SAMPLE_W-1:0] pending_samples [$];
  lid_word_t           expected_words [$];
  int                  errors = 0;
  bit                  hold_request = 1'b0;
  bit                  progress;

  // round(32768*sin(2*pi*k/P)) capped at 32767 by a Q30 Taylor series, quarter wave folded
  function automatic int quarter_wave(int unsigned r);
    longint unsigned ang, sq, acc, res;
    int unsigned     div [4] = '{72, 42, 20, 6};
    ang = ((longint'(r) << 30) / PERIOD) * 64'd1686629713 >> 30;
    sq  = (ang * ang) >> 30;
    acc = 64'd1073741824;
    foreach (div[i]) acc = 64'd1073741824 - ((sq * acc) >> 30) / div[i];
    res = (((ang * acc) >> 30) + 64'd16384) >> 15;
    return (res > 32767) ? 32767 : int'(res);
  endfunction

  function automatic logic signed [127:0] clamp(logic signed [127:0] v, int bits);
    logic signed [127:0] top;
    top = (128'sd1 <<< (bits - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  // advance the model by one accepted sample, queue any word it causes
  task automatic demodulate_sample(logic [11:0] smp);
    int unsigned         p;
    longint              prod;
    logic signed [127:0] mix, fb, y;
    lid_word_t           w;
    p = (load_pos >= BLK) ? 0 : load_pos;
    if (have_block) begin
      prod = (longint'(stored[p]) * 256 - longint'(mean_q8)) * sine_tab[p % PERIOD];
      mix  = 128'(last_product + prod);
      mix  = (mix * $signed({97'b0, in_gain_reg})) >>> 15;
      fb   = 128'(iir_state);
      fb   = (fb * $signed({97'b0, pole_reg})) >>> 31;
      y    = clamp(mix + fb, 53);
      iir_state    = longint'(y);
      last_product = prod;
      y = clamp((y * $signed({112'b0, out_gain_reg})) >>> 30, 37);
      w.demodulated = y[36:0];
      w.position    = p[8:0];
      w.block_end   = (p == BLK - 1);
      expected_words.push_back(w);
    end
    stored[p] = smp;
    load_sum += smp;
    if (p == BLK - 1) begin
      mean_q8    = (load_sum * 256 + BLK / 2) / BLK;
      load_sum   = 0;
      have_block = 1'b1;
      load_pos   = 0;
    end else begin
      load_pos = p + 1;
    end
  endtask

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // sender: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic nxt_valid;
    logic [SAMPLE_W-1:0] nxt_sample;
    nxt_valid  = in_valid;
    nxt_sample = in_sample;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        demodulate_sample(in_sample);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_samples.size() > 0) begin
          nxt_valid  = 1'b1;
          nxt_sample = pending_samples.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
    in_valid  <= nxt_valid;
    in_sample <= nxt_sample;
  end

  // receiver: its own stall pattern, plus one long hold on request
  int seg_left = 0;
  int seg_kind = 0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    logic nxt_ready;
    if (hold_request && !hold_done) begin
      hold_cnt++;
      if (hold_cnt >= LONG_HOLD) hold_done = 1'b1;
      nxt_ready = 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(5, 60);
        seg_kind = $urandom_range(0, 2);
      end
      seg_left--;
      case (seg_kind)
        0: nxt_ready = 1'b1;
        1: nxt_ready = ($urandom_range(0, 1) == 1);
        default: nxt_ready = ($urandom_range(0, 7) == 0);
      endcase
    end
    out_ready <= nxt_ready;
  end

  // result check
  always @(posedge clk) begin
    lid_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report("unexpected word", out_demodulated, 0);
      end else begin
        w = expected_words.pop_front();
        if (out_demodulated !== w.demodulated)
          report("demodulated", out_demodulated, w.demodulated);
        if (out_position !== w.position) report("position", out_position, w.position);
        if (out_block_end !== w.block_end) report("block_end", out_block_end, w.block_end);
      end
    end
  end

  // watchdog: cycles with no word moving on either channel
  int stuck = 0;
  always @(posedge clk) begin
    progress = (in_valid && in_ready) || (out_valid && out_ready);
    stuck = progress ? 0 : stuck + 1;
    if (stuck >= WD_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    case (idx)
      REG_POLE:     pole_reg     = val;
      REG_IN_GAIN:  in_gain_reg  = val;
      REG_OUT_GAIN: out_gain_reg = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    // the block may still be busy on a word-less sample or the mean division
    repeat (100) @(posedge clk);
  endtask

  // queue n samples in runs of random, locked-sine and near-constant content
  task automatic queue_samples(int n);
    int kind, amp, ph, lvl, run;
    while (n > 0) begin
      run  = $urandom_range(20, 80);
      kind = $urandom_range(0, 3);
      amp  = $urandom_range(0, 2047);
      ph   = $urandom_range(0, PERIOD - 1);
      lvl  = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(4055, 4095);
      for (int i = 0; i < run && n > 0; i++, n--) begin
        case (kind)
          0, 1: pending_samples.push_back(
                  12'(2048 + ((amp * sine_tab[(load_pos + i + ph) % PERIOD]) >>> 15)));
          2: pending_samples.push_back(12'(lvl + $urandom_range(0, 40) - 20 < 0 ? 0 :
               (lvl + $urandom_range(0, 40) > 4095 ? 4095 : lvl)));
          default: pending_samples.push_back(12'($urandom_range(0, 4095)));
        endcase
      end
    end
  endtask

  initial begin
    logic [11:0] directed [] = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'h555, 12'hAAA,
      12'd1, 12'd4094, 12'd2048, 12'd2047, 12'h800, 12'h7FF, 12'hF0F, 12'h0F0,
      12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd3, 12'd4092, 12'h123,
      12'hEDC, 12'd4095};
    for (int k = 0; k < PERIOD; k++) begin
      int q, quad, r, v;
      q    = 4 * k;
      quad = q / PERIOD;
      r    = q % PERIOD;
      v    = quad[0] ? quarter_wave(PERIOD - r) : quarter_wave(r);
      sine_tab[k] = quad[1] ? -v : v;
    end
    load_sum = 0; mean_q8 = 0; load_pos = 0; have_block = 0;
    last_product = 0; iir_state = 0;
    pole_reg = POLE_RESET; in_gain_reg = IN_GAIN_RESET; out_gain_reg = OUT_GAIN_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: first block gives no words
    foreach (directed[i]) pending_samples.push_back(directed[i]);
    queue_samples(300);
    drain();

    // maximum gains drive both saturation points; receiver holds off once
    write_reg(REG_POLE, 31'h7FFFFFFF);
    write_reg(REG_IN_GAIN, 31'h7FFFFFFF);
    write_reg(REG_OUT_GAIN, 31'h0000FFFF);
    write_reg(REG_UNUSED, 31'h12345678);
    hold_request = 1'b1;
    queue_samples(250);
    drain();

    write_reg(REG_POLE, 31'd0);
    write_reg(REG_IN_GAIN, 31'd0);
    write_reg(REG_OUT_GAIN, 31'd0);
    queue_samples(100);
    drain();

    write_reg(REG_POLE, 31'($urandom));
    write_reg(REG_IN_GAIN, 31'($urandom_range(0, 4000000)));
    write_reg(REG_OUT_GAIN, 31'($urandom_range(0, 65535)));
    queue_samples(125);
    drain();
    write_reg(REG_POLE, POLE_RESET);
    write_reg(REG_IN_GAIN, IN_GAIN_RESET);
    write_reg(REG_OUT_GAIN, 31'(OUT_GAIN_RESET));
    queue_samples(125);
    drain();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
